/* hdl/shell_command_lexer_macros.svh */
// Assertion macros shared by the command lexer RTL
`ifndef SHELL_COMMAND_LEXER_MACROS_SVH
`define SHELL_COMMAND_LEXER_MACROS_SVH

// check a consequence in the same cycle as its condition
`define SCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the cycle after its condition
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/scl_pkg.sv */
// Types, constants and helper functions of the command lexer
`timescale 1ns / 1ps

package scl_pkg;

	localparam logic [3:0] KIND_WORD = 4'd0;
	localparam logic [3:0] KIND_OR   = 4'd1;
	localparam logic [3:0] KIND_AND  = 4'd2;
	localparam logic [3:0] KIND_APP  = 4'd3;
	localparam logic [3:0] KIND_HERE = 4'd4;
	localparam logic [3:0] KIND_PIPE = 4'd5;
	localparam logic [3:0] KIND_BG   = 4'd6;
	localparam logic [3:0] KIND_OUT  = 4'd7;
	localparam logic [3:0] KIND_IN   = 4'd8;
	localparam logic [3:0] KIND_SEP  = 4'd9;

	localparam logic [7:0] CH_PIPE = 8'h7C;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_BSL  = 8'h5C;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		LM_IDLE   = 2'd0,
		LM_WORD   = 2'd1,
		LM_DQUOTE = 2'd2,
		LM_SQUOTE = 2'd3
	} lex_mode_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_PIPE = 3'd1,
		OP_AMP  = 3'd2,
		OP_GT   = 3'd3,
		OP_LT   = 3'd4
	} op_t;

	typedef struct packed {
		logic [3:0] kind;
		logic       carries;
		logic [7:0] chr;
		logic       tend;
	} result_t;

	typedef struct packed {
		result_t [2:0] res;
		logic [1:0]    cnt;
	} bundle_t;

	typedef struct packed {
		lex_mode_t mode;
		op_t       held;
		logic      esc;
	} status_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {[8'd9:8'd13], 8'd32};
	endfunction

	function automatic logic [7:0] op_pair_char(input op_t h);
		case (h)
			OP_PIPE: return CH_PIPE;
			OP_AMP:  return CH_AMP;
			OP_GT:   return CH_GT;
			OP_LT:   return CH_LT;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [3:0] op_pair_kind(input op_t h);
		case (h)
			OP_PIPE: return KIND_OR;
			OP_AMP:  return KIND_AND;
			OP_GT:   return KIND_APP;
			OP_LT:   return KIND_HERE;
			default: return KIND_WORD;
		endcase
	endfunction

	function automatic logic [3:0] op_single_kind(input op_t h);
		case (h)
			OP_PIPE: return KIND_PIPE;
			OP_AMP:  return KIND_BG;
			OP_GT:   return KIND_OUT;
			OP_LT:   return KIND_IN;
			default: return KIND_WORD;
		endcase
	endfunction

	function automatic result_t mk_char(input logic [7:0] c);
		result_t r;
		r.kind = KIND_WORD;
		r.carries = 1'b1;
		r.chr = c;
		r.tend = 1'b0;
		return r;
	endfunction

	function automatic result_t mk_end(input logic [3:0] k);
		result_t r;
		r.kind = k;
		r.carries = 1'b0;
		r.chr = 8'd0;
		r.tend = 1'b1;
		return r;
	endfunction

endpackage

/* hdl/scl_front.sv */
// Front end: accepts characters, tracks lexer state and builds result bundles
`timescale 1ns / 1ps

module scl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  logic             has_char,
	input  logic [7:0]       char_in,
	input  logic             line_end,
	input  logic             q_full,
	output logic             q_push,
	output scl_pkg::bundle_t q_data,
	output scl_pkg::status_t status
);

	scl_pkg::lex_mode_t mode_q, mode_f, mode_d;
	scl_pkg::op_t       held_q, held_f, held_d;
	logic               esc_q, esc_f, esc_d;
	logic               accept;
	logic               cv;
	logic               pair_hit;
	logic [7:0]         qchar;
	scl_pkg::result_t [3:0] res4;
	logic [1:0]         n;

	assign char_stall = q_full;
	assign accept = char_valid && !q_full;
	assign cv = has_char && (char_in != 8'd0);
	assign pair_hit = (held_q != scl_pkg::OP_NONE) && (char_in == scl_pkg::op_pair_char(held_q));
	assign qchar = (mode_q == scl_pkg::LM_DQUOTE) ? scl_pkg::CH_DQ : scl_pkg::CH_SQ;

	always_comb begin
		mode_f = mode_q;
		held_f = held_q;
		esc_f = esc_q;
		if (cv) begin
			case (mode_q)
				scl_pkg::LM_WORD: begin
					if (esc_q) begin
						esc_f = 1'b0;
						if (scl_pkg::is_blank(char_in))
							mode_f = scl_pkg::LM_IDLE;
					end else if (scl_pkg::is_blank(char_in)) begin
						mode_f = scl_pkg::LM_IDLE;
					end else if (char_in == scl_pkg::CH_BSL) begin
						esc_f = 1'b1;
					end
				end
				scl_pkg::LM_DQUOTE, scl_pkg::LM_SQUOTE: begin
					if (esc_q)
						esc_f = 1'b0;
					else if (char_in == qchar)
						mode_f = scl_pkg::LM_IDLE;
					else if (char_in == scl_pkg::CH_BSL)
						esc_f = 1'b1;
				end
				default: begin
					mode_f = scl_pkg::LM_IDLE;
					esc_f = 1'b0;
					held_f = scl_pkg::OP_NONE;
					if (!pair_hit) begin
						case (char_in)
							scl_pkg::CH_PIPE: held_f = scl_pkg::OP_PIPE;
							scl_pkg::CH_AMP:  held_f = scl_pkg::OP_AMP;
							scl_pkg::CH_GT:   held_f = scl_pkg::OP_GT;
							scl_pkg::CH_LT:   held_f = scl_pkg::OP_LT;
							scl_pkg::CH_SEMI: held_f = scl_pkg::OP_NONE;
							scl_pkg::CH_DQ:   mode_f = scl_pkg::LM_DQUOTE;
							scl_pkg::CH_SQ:   mode_f = scl_pkg::LM_SQUOTE;
							scl_pkg::CH_BSL: begin
								mode_f = scl_pkg::LM_WORD;
								esc_f = 1'b1;
							end
							default: begin
								if (!scl_pkg::is_blank(char_in))
									mode_f = scl_pkg::LM_WORD;
							end
						endcase
					end
				end
			endcase
		end
		if (line_end) begin
			mode_d = scl_pkg::LM_IDLE;
			held_d = scl_pkg::OP_NONE;
			esc_d = 1'b0;
		end else begin
			mode_d = mode_f;
			held_d = held_f;
			esc_d = esc_f;
		end
	end

	always_comb begin
		res4 = '0;
		n = 2'd0;
		if (cv) begin
			case (mode_q)
				scl_pkg::LM_WORD: begin
					if (esc_q) begin
						if (scl_pkg::is_blank(char_in)) begin
							res4[n] = scl_pkg::mk_char(scl_pkg::CH_BSL);
							n = n + 2'd1;
							res4[n] = scl_pkg::mk_end(scl_pkg::KIND_WORD);
							n = n + 2'd1;
						end else begin
							res4[n] = scl_pkg::mk_char(char_in);
							n = n + 2'd1;
						end
					end else if (scl_pkg::is_blank(char_in)) begin
						res4[n] = scl_pkg::mk_end(scl_pkg::KIND_WORD);
						n = n + 2'd1;
					end else if (char_in != scl_pkg::CH_BSL) begin
						res4[n] = scl_pkg::mk_char(char_in);
						n = n + 2'd1;
					end
				end
				scl_pkg::LM_DQUOTE, scl_pkg::LM_SQUOTE: begin
					if (esc_q) begin
						res4[n] = scl_pkg::mk_char(char_in);
						n = n + 2'd1;
					end else if (char_in == qchar) begin
						res4[n] = scl_pkg::mk_end(scl_pkg::KIND_WORD);
						n = n + 2'd1;
					end else if (char_in != scl_pkg::CH_BSL) begin
						res4[n] = scl_pkg::mk_char(char_in);
						n = n + 2'd1;
					end
				end
				default: begin
					if (held_q != scl_pkg::OP_NONE) begin
						if (pair_hit)
							res4[n] = scl_pkg::mk_end(scl_pkg::op_pair_kind(held_q));
						else
							res4[n] = scl_pkg::mk_end(scl_pkg::op_single_kind(held_q));
						n = n + 2'd1;
					end
					if (!pair_hit && !scl_pkg::is_blank(char_in)) begin
						if (char_in == scl_pkg::CH_SEMI) begin
							res4[n] = scl_pkg::mk_end(scl_pkg::KIND_SEP);
							n = n + 2'd1;
						end else if (!(char_in inside {scl_pkg::CH_PIPE, scl_pkg::CH_AMP,
								scl_pkg::CH_GT, scl_pkg::CH_LT, scl_pkg::CH_DQ,
								scl_pkg::CH_SQ, scl_pkg::CH_BSL})) begin
							res4[n] = scl_pkg::mk_char(char_in);
							n = n + 2'd1;
						end
					end
				end
			endcase
		end
		if (line_end) begin
			if (held_f != scl_pkg::OP_NONE) begin
				res4[n] = scl_pkg::mk_end(scl_pkg::op_single_kind(held_f));
				n = n + 2'd1;
			end
			if (mode_f != scl_pkg::LM_IDLE) begin
				if (esc_f) begin
					res4[n] = scl_pkg::mk_char(scl_pkg::CH_BSL);
					n = n + 2'd1;
				end
				res4[n] = scl_pkg::mk_end(scl_pkg::KIND_WORD);
				n = n + 2'd1;
			end
		end
	end

	assign q_push = accept && (n != 2'd0);
	assign q_data.res = res4[2:0];
	assign q_data.cnt = n;

	assign status.mode = mode_q;
	assign status.held = held_q;
	assign status.esc = esc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= scl_pkg::LM_IDLE;
			held_q <= scl_pkg::OP_NONE;
			esc_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			esc_q <= esc_d;
		end
	end

endmodule

/* hdl/scl_queue.sv */
// Short queue of result bundles between the front and back ends
`timescale 1ns / 1ps

module scl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  scl_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output scl_pkg::bundle_t head,
	output logic             empty
);

	scl_pkg::bundle_t         slots [scl_pkg::QDEPTH];
	logic [scl_pkg::QAW-1:0]  wr_q, rd_q;
	logic [scl_pkg::QAW:0]    cnt_q;

	assign full = (cnt_q == (scl_pkg::QAW+1)'(scl_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = slots[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + (scl_pkg::QAW)'(1);
			if (pop)
				rd_q <= rd_q + (scl_pkg::QAW)'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (scl_pkg::QAW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (scl_pkg::QAW+1)'(1);
		end
	end

endmodule

/* hdl/scl_back.sv */
// Back end: walks each bundle and drives one token result per cycle while token_stall is low
`timescale 1ns / 1ps

module scl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  scl_pkg::bundle_t q_head,
	output logic             q_pop,
	output logic             token_valid,
	input  logic             token_stall,
	output logic [3:0]       token_kind,
	output logic             carries_char,
	output logic [7:0]       char_out,
	output logic             token_end,
	output logic             last
);

	logic [1:0]       sel_q;
	logic             valid_q;
	logic             load;
	logic             is_last;
	scl_pkg::result_t cur;

	assign cur = q_head.res[sel_q];
	assign is_last = (sel_q == (q_head.cnt - 2'd1));
	assign load = !q_empty && (!valid_q || !token_stall);
	assign q_pop = load && is_last;
	assign token_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q <= is_last ? 2'd0 : sel_q + 2'd1;
		end else if (!token_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_kind <= cur.kind;
			carries_char <= cur.carries;
			char_out <= cur.chr;
			token_end <= cur.tend;
			last <= is_last;
		end
	end

endmodule

/* hdl/shell_command_lexer.sv */
// Streaming shell command line lexer.
// Request channel: char_valid / char_stall carry has_char, char_in and
// line_end, one character (or a bare line end) per request.
// Token channel: token_valid / token_stall carry one result per transfer:
// token_kind, carries_char, char_out, token_end, and last on the final
// result caused by an input request. A request may cause zero to three.
// The first result of a request is written into the queue on the edge that
// accepts the request and is then loaded into the output register once
// that register is free.
// Throughput: one request per cycle while token_stall is low and each
// causes at most one result; the single token output register sets the
// pace, so each result of a request takes its own output transfer.
// A four-entry queue of result bundles sits between the classifier and
// the output; char_stall rises only while that queue is full.
// Reset clears the lexer state, the queue and the output valid.
// While token_stall is high the current result holds and the queue
// fills; requests keep being taken until it is full.
`timescale 1ns / 1ps
`include "shell_command_lexer_macros.svh"

module shell_command_lexer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic       has_char,
	input  logic [7:0] char_in,
	input  logic       line_end,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [3:0] token_kind,
	output logic       carries_char,
	output logic [7:0] char_out,
	output logic       token_end,
	output logic       last
);

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	scl_pkg::bundle_t q_data;
	scl_pkg::bundle_t q_head;
	scl_pkg::status_t status;

	scl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.has_char   (has_char),
		.char_in    (char_in),
		.line_end   (line_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data),
		.status     (status)
	);

	scl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	scl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.carries_char (carries_char),
		.char_out     (char_out),
		.token_end    (token_end),
		.last         (last)
	);

	`SCL_ASSERT_NEXT(a_flush_idle,
		char_valid && !char_stall && line_end,
		status.mode == scl_pkg::LM_IDLE && status.held == scl_pkg::OP_NONE && !status.esc,
		"lexer state not cleared by line end")
	`SCL_ASSERT_NOW(a_word_char,
		token_valid && !token_end,
		carries_char && token_kind == scl_pkg::KIND_WORD,
		"non-final result is not a word character")
	`SCL_ASSERT_NEXT(a_drain,
		!token_valid && !q_empty,
		token_valid,
		"queued results not moved to output")

endmodule
